@@ hdl/bsf_pkg.sv @@
// Package for the barycentric surface frame block: word types, opcodes and
// fixed-point step functions. No dependencies.
`timescale 1ns / 1ps

package bsf_pkg;

    localparam int VERTICES_DEF = 1024;
    localparam int SQ_STEPS     = 30;   // root bits of floor(sqrt(len2 << 16))
    localparam int DV_STEPS     = 21;   // quotient bits of the unit scale

    localparam logic [1:0] OP_LOAD_POS = 2'd0;
    localparam logic [1:0] OP_LOAD_NRM = 2'd1;
    localparam logic [1:0] OP_FRAME    = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [9:0]         load_index;
        logic [62:0]        load_vector;
        logic [9:0]         corner_a_index;
        logic [9:0]         corner_b_index;
        logic [9:0]         corner_c_index;
        logic signed [15:0] weight_a;
        logic signed [15:0] weight_b;
        logic signed [15:0] weight_c;
    } t_in_word;

    typedef struct packed {
        logic        is_frame;
        logic [62:0] axis_x;
        logic [62:0] axis_y;
        logic [62:0] axis_z;
        logic [62:0] origin_out;
        logic [62:0] up_out;
    } t_out_word;

    typedef logic signed [20:0] t_c21;
    typedef logic [2:0][21:0]   t_v22;

    // travels alongside the normalizer lanes
    typedef struct packed {
        logic        valid;
        logic        is_frame;
        logic [62:0] origin;
    } t_tag;

    typedef struct packed {
        logic [2:0]       sign;
        logic [2:0][20:0] mag;
        logic             zero;
    } t_lane;

    typedef struct packed {
        logic [31:0] rem;
        logic [29:0] root;
        logic [59:0] x;
    } t_sq;

    typedef struct packed {
        logic [29:0] r;
        logic [20:0] d;
        logic [20:0] q;
    } t_dv;

    function automatic t_c21 comp(logic [62:0] v, int i);
        return t_c21'(v[21*i +: 21]);
    endfunction

    function automatic t_c21 sat21(logic signed [44:0] v);
        if (v > 45'sd1048575) return 21'sd1048575;
        if (v < -45'sd1048576) return -21'sd1048576;
        return v[20:0];
    endfunction

    // (p - q) / 2^19, round half up, saturated
    function automatic t_c21 cross_round(logic signed [41:0] p, logic signed [41:0] q);
        logic signed [42:0] d;
        d = 43'(p) - 43'(q) + 43'sd262144;
        return sat21(45'(d >>> 19));
    endfunction

    // one bit of restoring square root
    function automatic t_sq sqrt_step(t_sq s);
        logic [33:0] cur;
        logic [33:0] trial;
        t_sq         o;
        cur   = {s.rem, s.x[59:58]};
        trial = {2'b00, s.root, 2'b01};
        o.x   = {s.x[57:0], 2'b00};
        if (cur >= trial) begin
            o.rem  = 32'(cur - trial);
            o.root = {s.root[28:0], 1'b1};
        end else begin
            o.rem  = cur[31:0];
            o.root = {s.root[28:0], 1'b0};
        end
        return o;
    endfunction

    // one bit of restoring division by n
    function automatic t_dv div_step(t_dv s, logic [29:0] n);
        logic [30:0] cur;
        t_dv         o;
        cur = {s.r, s.d[20]};
        o.d = {s.d[19:0], 1'b0};
        if (cur >= {1'b0, n}) begin
            o.r = 30'(cur - {1'b0, n});
            o.q = {s.q[19:0], 1'b1};
        end else begin
            o.r = cur[29:0];
            o.q = {s.q[19:0], 1'b0};
        end
        return o;
    endfunction

endpackage

@@ hdl/bsf_norm.sv @@
// Two-lane pipelined vector normalizer: squares, sum, bit-serial root stages,
// restoring divide stages. Depends on bsf_pkg.
`timescale 1ns / 1ps

module bsf_norm import bsf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_tag             i_tag,
    input  t_v22 [1:0]       i_vec,
    output t_tag             o_tag,
    output logic [1:0][62:0] o_vec
);

    t_tag        r_tag0;
    t_lane [1:0] r_ln0;
    logic [41:0] r_sqr [2][3];

    t_tag        r_tag_s [SQ_STEPS+1];
    t_lane [1:0] r_ln_s  [SQ_STEPS+1];
    t_sq   [1:0] r_sq_s  [SQ_STEPS+1];

    t_tag        r_tag_d [DV_STEPS+1];
    t_lane [1:0] r_ln_d  [DV_STEPS+1];
    logic [1:0][29:0]   r_n_d  [DV_STEPS+1];
    t_dv  [1:0][2:0]    r_dv_d [DV_STEPS+1];

    t_tag             r_tag_o;
    logic [1:0][62:0] r_vec_o;

    t_lane [1:0] n_ln0;
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            for (int i = 0; i < 3; i++) begin
                n_ln0[l].sign[i] = i_vec[l][i][21];
                n_ln0[l].mag[i]  = i_vec[l][i][21] ? 21'(-$signed(i_vec[l][i]))
                                                   : i_vec[l][i][20:0];
            end
            n_ln0[l].zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag0.valid <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++) r_tag_s[k].valid <= 1'b0;
            for (int k = 0; k <= DV_STEPS; k++) r_tag_d[k].valid <= 1'b0;
            r_tag_o.valid <= 1'b0;
        end else if (i_en) begin
            // squares
            r_tag0 <= i_tag;
            r_ln0  <= n_ln0;
            for (int l = 0; l < 2; l++)
                for (int i = 0; i < 3; i++)
                    r_sqr[l][i] <= n_ln0[l].mag[i] * n_ln0[l].mag[i];
            // length squared, root setup
            r_tag_s[0] <= r_tag0;
            for (int l = 0; l < 2; l++) begin
                logic [43:0] len2;
                len2 = 44'(r_sqr[l][0]) + 44'(r_sqr[l][1]) + 44'(r_sqr[l][2]);
                r_ln_s[0][l]      <= '{sign: r_ln0[l].sign, mag: r_ln0[l].mag,
                                       zero: (len2 == 44'd0)};
                r_sq_s[0][l].rem  <= '0;
                r_sq_s[0][l].root <= '0;
                r_sq_s[0][l].x    <= {len2, 16'd0};
            end
            // root stages
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_tag_s[k+1] <= r_tag_s[k];
                r_ln_s[k+1]  <= r_ln_s[k];
                for (int l = 0; l < 2; l++)
                    r_sq_s[k+1][l] <= sqrt_step(r_sq_s[k][l]);
            end
            // divide setup: dividend |c| << 27 plus n/2
            r_tag_d[0] <= r_tag_s[SQ_STEPS];
            r_ln_d[0]  <= r_ln_s[SQ_STEPS];
            for (int l = 0; l < 2; l++) begin
                r_n_d[0][l] <= r_sq_s[SQ_STEPS][l].root;
                for (int i = 0; i < 3; i++) begin
                    logic [48:0] dd;
                    dd = {1'b0, r_ln_s[SQ_STEPS][l].mag[i], 27'd0}
                       + 49'(r_sq_s[SQ_STEPS][l].root[29:1]);
                    r_dv_d[0][l][i].r <= 30'(dd[48:21]);
                    r_dv_d[0][l][i].d <= dd[20:0];
                    r_dv_d[0][l][i].q <= '0;
                end
            end
            // divide stages
            for (int k = 0; k < DV_STEPS; k++) begin
                r_tag_d[k+1] <= r_tag_d[k];
                r_ln_d[k+1]  <= r_ln_d[k];
                r_n_d[k+1]   <= r_n_d[k];
                for (int l = 0; l < 2; l++)
                    for (int i = 0; i < 3; i++)
                        r_dv_d[k+1][l][i] <= div_step(r_dv_d[k][l][i], r_n_d[k][l]);
            end
            // sign, zero vector
            r_tag_o <= r_tag_d[DV_STEPS];
            for (int l = 0; l < 2; l++)
                for (int i = 0; i < 3; i++)
                    r_vec_o[l][21*i +: 21] <= r_ln_d[DV_STEPS][l].zero ? 21'd0 :
                        r_ln_d[DV_STEPS][l].sign[i] ? 21'(-r_dv_d[DV_STEPS][l][i].q)
                                                    : r_dv_d[DV_STEPS][l][i].q;
        end
    end

    assign o_tag = r_tag_o;
    assign o_vec = r_vec_o;

endmodule

@@ hdl/barycentric_surface_frame_top.sv @@
// Top level of the barycentric surface frame block: vertex tables, weighting,
// up selection, cross products, output register. Depends on bsf_pkg, bsf_norm.
`timescale 1ns / 1ps

// channel   dir   handshake          word
// -------   ---   ----------------   ----------------------------------
// input     in    i_valid / o_ready  t_in_word  (load or compute item)
// output    out   o_valid / i_ready  t_out_word (frame, or zeros for other ops)
//
// One word enters per cycle while o_ready is high; the pipe holds 4 front stages,
// 55 normalizer stages (30 root bits, 21 quotient bits) and 4 cross stages, plus the output reg.
// The two normalizer lanes (normal and up) run side by side.
// Synchronous active-low reset clears valid bits only; tables are undefined
// until loaded. A stalled output freezes the pipe only when its last stage
// is full, so a bubble there still lets new words in.

module barycentric_surface_frame_top import bsf_pkg::*; #(
    parameter int VERTICES = VERTICES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_in,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_out
);

    localparam int AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;

    // tables, duplicated for a third read port
    logic [62:0] mem_pos0 [VERTICES];
    logic [62:0] mem_pos1 [VERTICES];
    logic [62:0] mem_nrm0 [VERTICES];
    logic [62:0] mem_nrm1 [VERTICES];

    logic w_out_free, w_run, w_acc, w_wr_pos, w_wr_nrm;
    logic [AW-1:0] w_wa, w_ra, w_rb, w_rc;

    // stage 1: table read data
    logic r_s1_v, r_s1_frame, r_s1_fa, r_s1_fb, r_s1_fc;
    logic signed [15:0] r_s1_w [3];
    logic [62:0] r_pa, r_pb, r_pc, r_na, r_nb, r_nc;
    // stage 2: weighted products
    logic r_s2_v, r_s2_frame;
    logic signed [36:0] r_pp [3][3];
    logic signed [36:0] r_np [3][3];
    logic [62:0] r_s2_plow;
    // stage 3: origin and normal sum
    logic r_s3_v, r_s3_frame;
    t_c21 r_org [3];
    t_c21 r_nsum [3];
    logic [62:0] r_s3_plow;
    // stage 4: normalizer input
    t_tag       r_s4_tag;
    t_v22 [1:0] r_s4_vec;
    t_tag             w_n_tag;
    logic [1:0][62:0] w_n_vec;
    // cross stages
    t_tag r_c0_tag, r_c1_tag, r_c2_tag, r_c3_tag;
    logic [62:0] r_c0_axy, r_c0_up, r_c1_axy, r_c1_up, r_c1_ax;
    logic [62:0] r_c2_axy, r_c2_up, r_c2_ax, r_c3_axy, r_c3_up, r_c3_ax, r_c3_az;
    logic signed [41:0] r_c0_p [6];
    logic signed [41:0] r_c2_p [6];
    // output
    logic      r_out_valid;
    t_out_word r_out;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_run      = !r_c3_tag.valid || w_out_free;
    assign o_ready    = w_run;
    assign w_acc      = i_valid && w_run;
    assign w_wa       = AW'(i_in.load_index);
    assign w_ra       = AW'(i_in.corner_a_index);
    assign w_rb       = AW'(i_in.corner_b_index);
    assign w_rc       = AW'(i_in.corner_c_index);
    assign w_wr_pos   = w_acc && (i_in.opcode == OP_LOAD_POS)
                        && (32'(i_in.load_index) < VERTICES);
    assign w_wr_nrm   = w_acc && (i_in.opcode == OP_LOAD_NRM)
                        && (32'(i_in.load_index) < VERTICES);

    always_ff @(posedge i_clk) begin
        if (w_wr_pos) begin
            mem_pos0[w_wa] <= i_in.load_vector;
            mem_pos1[w_wa] <= i_in.load_vector;
        end
        if (w_wr_nrm) begin
            mem_nrm0[w_wa] <= i_in.load_vector;
            mem_nrm1[w_wa] <= i_in.load_vector;
        end
        if (w_run) begin
            r_pa <= mem_pos0[w_ra];
            r_pb <= mem_pos0[w_rb];
            r_pc <= mem_pos1[w_rc];
            r_na <= mem_nrm0[w_ra];
            r_nb <= mem_nrm0[w_rb];
            r_nc <= mem_nrm1[w_rc];
        end
    end

    // out-of-range corners read as zero
    logic [62:0] w_p [3];
    logic [62:0] w_n [3];
    logic [1:0]  w_low;
    always_comb begin
        w_p[0] = r_s1_fa ? r_pa : '0;
        w_p[1] = r_s1_fb ? r_pb : '0;
        w_p[2] = r_s1_fc ? r_pc : '0;
        w_n[0] = r_s1_fa ? r_na : '0;
        w_n[1] = r_s1_fb ? r_nb : '0;
        w_n[2] = r_s1_fc ? r_nc : '0;
        // lowest weight, first corner wins ties
        w_low = 2'd0;
        if (r_s1_w[1] < r_s1_w[0]) w_low = 2'd1;
        if (r_s1_w[2] < r_s1_w[w_low]) w_low = 2'd2;
    end

    t_c21 n_org [3];
    t_c21 n_nsum [3];
    always_comb begin
        logic signed [38:0] so, sn;
        for (int i = 0; i < 3; i++) begin
            so = 39'(r_pp[0][i]) + 39'(r_pp[1][i]) + 39'(r_pp[2][i]) + 39'sd8192;
            sn = 39'(r_np[0][i]) + 39'(r_np[1][i]) + 39'(r_np[2][i]) + 39'sd8192;
            n_org[i]  = sat21(45'(so >>> 14));
            n_nsum[i] = sat21(45'(sn >>> 14));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v         <= 1'b0;
            r_s2_v         <= 1'b0;
            r_s3_v         <= 1'b0;
            r_s4_tag.valid <= 1'b0;
            r_c0_tag.valid <= 1'b0;
            r_c1_tag.valid <= 1'b0;
            r_c2_tag.valid <= 1'b0;
            r_c3_tag.valid <= 1'b0;
        end else if (w_run) begin
            r_s1_v     <= w_acc;
            r_s1_frame <= (i_in.opcode == OP_FRAME);
            r_s1_fa    <= (32'(i_in.corner_a_index) < VERTICES);
            r_s1_fb    <= (32'(i_in.corner_b_index) < VERTICES);
            r_s1_fc    <= (32'(i_in.corner_c_index) < VERTICES);
            r_s1_w[0]  <= i_in.weight_a;
            r_s1_w[1]  <= i_in.weight_b;
            r_s1_w[2]  <= i_in.weight_c;

            r_s2_v     <= r_s1_v;
            r_s2_frame <= r_s1_frame;
            r_s2_plow  <= w_p[w_low];
            for (int k = 0; k < 3; k++)
                for (int i = 0; i < 3; i++) begin
                    r_pp[k][i] <= comp(w_p[k], i) * r_s1_w[k];
                    r_np[k][i] <= comp(w_n[k], i) * r_s1_w[k];
                end

            r_s3_v     <= r_s2_v;
            r_s3_frame <= r_s2_frame;
            r_s3_plow  <= r_s2_plow;
            r_org      <= n_org;
            r_nsum     <= n_nsum;

            // up = low corner - origin, unsaturated
            r_s4_tag.valid    <= r_s3_v;
            r_s4_tag.is_frame <= r_s3_frame;
            r_s4_tag.origin   <= {r_org[2], r_org[1], r_org[0]};
            for (int i = 0; i < 3; i++) begin
                r_s4_vec[0][i] <= 22'(r_nsum[i]);
                r_s4_vec[1][i] <= 22'(comp(r_s3_plow, i)) - 22'(r_org[i]);
            end

            // x = normal cross up
            r_c0_tag  <= w_n_tag;
            r_c0_axy  <= w_n_vec[0];
            r_c0_up   <= w_n_vec[1];
            r_c0_p[0] <= comp(w_n_vec[0], 1) * comp(w_n_vec[1], 2);
            r_c0_p[1] <= comp(w_n_vec[0], 2) * comp(w_n_vec[1], 1);
            r_c0_p[2] <= comp(w_n_vec[0], 2) * comp(w_n_vec[1], 0);
            r_c0_p[3] <= comp(w_n_vec[0], 0) * comp(w_n_vec[1], 2);
            r_c0_p[4] <= comp(w_n_vec[0], 0) * comp(w_n_vec[1], 1);
            r_c0_p[5] <= comp(w_n_vec[0], 1) * comp(w_n_vec[1], 0);

            r_c1_tag <= r_c0_tag;
            r_c1_axy <= r_c0_axy;
            r_c1_up  <= r_c0_up;
            r_c1_ax  <= {cross_round(r_c0_p[4], r_c0_p[5]),
                         cross_round(r_c0_p[2], r_c0_p[3]),
                         cross_round(r_c0_p[0], r_c0_p[1])};

            // z = normal cross x, from the saturated x
            r_c2_tag  <= r_c1_tag;
            r_c2_axy  <= r_c1_axy;
            r_c2_up   <= r_c1_up;
            r_c2_ax   <= r_c1_ax;
            r_c2_p[0] <= comp(r_c1_axy, 1) * comp(r_c1_ax, 2);
            r_c2_p[1] <= comp(r_c1_axy, 2) * comp(r_c1_ax, 1);
            r_c2_p[2] <= comp(r_c1_axy, 2) * comp(r_c1_ax, 0);
            r_c2_p[3] <= comp(r_c1_axy, 0) * comp(r_c1_ax, 2);
            r_c2_p[4] <= comp(r_c1_axy, 0) * comp(r_c1_ax, 1);
            r_c2_p[5] <= comp(r_c1_axy, 1) * comp(r_c1_ax, 0);

            r_c3_tag <= r_c2_tag;
            r_c3_axy <= r_c2_axy;
            r_c3_up  <= r_c2_up;
            r_c3_ax  <= r_c2_ax;
            r_c3_az  <= {cross_round(r_c2_p[4], r_c2_p[5]),
                         cross_round(r_c2_p[2], r_c2_p[3]),
                         cross_round(r_c2_p[0], r_c2_p[1])};
        end
    end

    bsf_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_run),
        .i_tag   (r_s4_tag),
        .i_vec   (r_s4_vec),
        .o_tag   (w_n_tag),
        .o_vec   (w_n_vec)
    );

    // output register; loads and unused opcodes answer with zeros
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid      <= r_c3_tag.valid;
            r_out.is_frame   <= r_c3_tag.is_frame;
            r_out.axis_x     <= r_c3_tag.is_frame ? r_c3_ax : '0;
            r_out.axis_y     <= r_c3_tag.is_frame ? r_c3_axy : '0;
            r_out.axis_z     <= r_c3_tag.is_frame ? r_c3_az : '0;
            r_out.origin_out <= r_c3_tag.is_frame ? r_c3_tag.origin : '0;
            r_out.up_out     <= r_c3_tag.is_frame ? r_c3_up : '0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

@@ verif/tb.sv @@
// Testbench for barycentric_surface_frame_top: loads a mesh table, sends frame
// items and unused opcodes, and compares every result word with an in-bench
// fixed-point predictor. Depends on bsf_pkg and barycentric_surface_frame_top.
`timescale 1ns / 1ps

module tb;
    import bsf_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int TAIL_CYCLES = 100;   // pipe is about 64 deep
    localparam int RANDOM_ITEMS = 1050;

    typedef longint t_vec [3];

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_in;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_out;

    barycentric_surface_frame_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // Mesh mirror and predictor state
    // ------------------------------------------------------------------
    logic [62:0] mesh_pos [1024];
    logic [62:0] mesh_nrm [1024];
    bit          pos_set  [1024];
    bit          nrm_set  [1024];
    int          live_idx [$];      // entries with both position and normal written
    t_out_word   frame_q  [$];      // expected result words, oldest first
    int          err_count;
    int          burst_left;
    int          burst_nogap;       // nonzero: current burst has no gaps at all

    // ------------------------------------------------------------------
    // Fixed-point helpers
    // ------------------------------------------------------------------
    function automatic longint comp_of(logic [62:0] v, int i);
        logic signed [20:0] c;
        c = v[21*i +: 21];
        return longint'(c);
    endfunction

    function automatic longint clamp21(longint v);
        if (v > 64'sd1048575) return 64'sd1048575;
        if (v < -64'sd1048576) return -64'sd1048576;
        return v;
    endfunction

    // round half up, arithmetic shift floors negative values
    function automatic longint rnd_shift(longint v, int n);
        longint t;
        t = v + (64'sd1 <<< (n - 1));
        return t >>> n;
    endfunction

    function automatic logic [62:0] pack3(t_vec c);
        logic [20:0] x, y, z;
        x = c[0][20:0];
        y = c[1][20:0];
        z = c[2][20:0];
        return {z, y, x};
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_vec unit_vec(t_vec c);
        t_vec            o;
        longint unsigned len2, n, a, q;
        len2 = 0;
        for (int i = 0; i < 3; i++) len2 += longint'(c[i] * c[i]);
        if (len2 == 0) begin
            o = '{0, 0, 0};
            return o;
        end
        n = int_sqrt(len2 << 16);
        for (int i = 0; i < 3; i++) begin
            a = longint'(c[i] < 0 ? -c[i] : c[i]) << 27;
            q = (a + n / 2) / n;
            o[i] = clamp21(c[i] < 0 ? -longint'(q) : longint'(q));
        end
        return o;
    endfunction

    function automatic t_vec cross3(t_vec a, t_vec b);
        t_vec o;
        o[0] = clamp21(rnd_shift(a[1] * b[2] - a[2] * b[1], 19));
        o[1] = clamp21(rnd_shift(a[2] * b[0] - a[0] * b[2], 19));
        o[2] = clamp21(rnd_shift(a[0] * b[1] - a[1] * b[0], 19));
        return o;
    endfunction

    // Applies one accepted word to the mesh mirror and queues its result.
    task automatic advance_mesh(t_in_word w);
        t_out_word   r;
        t_vec        org, nsum, axy, upv, upn, ax, az;
        longint      wt [3];
        logic [9:0]  idx [3];
        int          low;
        longint      so, sn;
        r = '0;
        if (w.opcode == OP_LOAD_POS) begin
            mesh_pos[w.load_index] = w.load_vector;
        end else if (w.opcode == OP_LOAD_NRM) begin
            mesh_nrm[w.load_index] = w.load_vector;
        end else if (w.opcode == OP_FRAME) begin
            idx = '{w.corner_a_index, w.corner_b_index, w.corner_c_index};
            wt  = '{longint'(w.weight_a), longint'(w.weight_b), longint'(w.weight_c)};
            for (int i = 0; i < 3; i++) begin
                so = 0;
                sn = 0;
                for (int k = 0; k < 3; k++) begin
                    so += comp_of(mesh_pos[idx[k]], i) * wt[k];
                    sn += comp_of(mesh_nrm[idx[k]], i) * wt[k];
                end
                org[i]  = clamp21(rnd_shift(so, 14));
                nsum[i] = clamp21(rnd_shift(sn, 14));
            end
            axy = unit_vec(nsum);
            // lowest weight picks the up corner; first one wins on ties
            low = 0;
            for (int k = 1; k < 3; k++) if (wt[k] < wt[low]) low = k;
            for (int i = 0; i < 3; i++) upv[i] = comp_of(mesh_pos[idx[low]], i) - org[i];
            upn = unit_vec(upv);
            ax  = cross3(axy, upn);
            az  = cross3(axy, ax);
            r.is_frame   = 1'b1;
            r.axis_x     = pack3(ax);
            r.axis_y     = pack3(axy);
            r.axis_z     = pack3(az);
            r.origin_out = pack3(org);
            r.up_out     = pack3(upn);
        end
        frame_q.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string what, logic [62:0] got, logic [62:0] want);
        err_count++;
        if (err_count <= 40)
            $display("MISMATCH %s: got %h want %h", what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid && i_ready) begin
            if (frame_q.size() == 0) begin
                flag_mismatch("unexpected word", o_out.axis_y, '0);
            end else begin
                e = frame_q.pop_front();
                if (o_out.is_frame !== e.is_frame)
                    flag_mismatch("is_frame", 63'(o_out.is_frame), 63'(e.is_frame));
                if (o_out.axis_x !== e.axis_x)
                    flag_mismatch("axis_x", o_out.axis_x, e.axis_x);
                if (o_out.axis_y !== e.axis_y)
                    flag_mismatch("axis_y", o_out.axis_y, e.axis_y);
                if (o_out.axis_z !== e.axis_z)
                    flag_mismatch("axis_z", o_out.axis_z, e.axis_z);
                if (o_out.origin_out !== e.origin_out)
                    flag_mismatch("origin_out", o_out.origin_out, e.origin_out);
                if (o_out.up_out !== e.up_out)
                    flag_mismatch("up_out", o_out.up_out, e.up_out);
            end
        end
    end

    // Watchdog: ends the run if neither side moves a word for too long.
    int idle_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("barycentric_surface_frame_top test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver stall pattern: switches between randomly drawn modes.
    int rx_mode, rx_left, rx_tick;
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(64, 250);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0: i_ready <= 1'b1;                            // no stalls
            1: i_ready <= ($urandom_range(0, 1) == 1);
            2: i_ready <= (rx_tick % 9 == 0);              // long stalls
            default: i_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Drives one word at a falling edge, holds it until accepted, then
    // predicts. Gaps between bursts drop valid on their own falling edges.
    task automatic send_word(t_in_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left  = $urandom_range(1, 24);
            burst_nogap = ($urandom_range(0, 3) == 0);
            gap = burst_nogap ? 0 : $urandom_range(1, 6);
        end else begin
            gap = 0;
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= w;
        do @(posedge i_clk); while (!o_ready);
        advance_mesh(w);
    endtask

    // Stops sending and waits until every expected word has come back.
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------
    function automatic t_in_word noise_word();
        t_in_word     w;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        w = t_in_word'(raw[$bits(t_in_word)-1:0]);
        return w;
    endfunction

    function automatic logic [62:0] pick_pos();
        logic [62:0] v;
        if ($urandom_range(0, 3) == 0) begin
            v = 63'({$urandom, $urandom});              // full range, can drive sums into saturation
        end else begin
            for (int i = 0; i < 3; i++)
                v[21*i +: 21] = 21'($signed($urandom_range(0, 65535)) - 32768);
        end
        return v;
    endfunction

    function automatic logic [62:0] pick_nrm();
        logic [62:0] v;
        if ($urandom_range(0, 3) == 0) begin
            v = 63'({$urandom, $urandom});
        end else begin
            for (int i = 0; i < 3; i++)
                v[21*i +: 21] = 21'($signed($urandom_range(0, 1048576)) - 524288);
        end
        return v;
    endfunction

    function automatic t_in_word load_word(logic [1:0] op, logic [9:0] ix, logic [62:0] v);
        t_in_word w;
        w = noise_word();
        w.opcode      = op;
        w.load_index  = ix;
        w.load_vector = v;
        return w;
    endfunction

    function automatic t_in_word frame_word(logic [9:0] a, logic [9:0] b, logic [9:0] c,
                                            logic [15:0] wa, logic [15:0] wb,
                                            logic [15:0] wc);
        t_in_word w;
        w = noise_word();
        w.opcode         = OP_FRAME;
        w.corner_a_index = a;
        w.corner_b_index = b;
        w.corner_c_index = c;
        w.weight_a       = wa;
        w.weight_b       = wb;
        w.weight_c       = wc;
        return w;
    endfunction

    // position then normal, keeps the set of readable entries current
    task automatic load_vertex(logic [9:0] ix, logic [62:0] p, logic [62:0] n);
        send_word(load_word(OP_LOAD_POS, ix, p));
        send_word(load_word(OP_LOAD_NRM, ix, n));
        if (!(pos_set[ix] && nrm_set[ix])) live_idx.push_back(ix);
        pos_set[ix] = 1'b1;
        nrm_set[ix] = 1'b1;
    endtask

    function automatic logic [9:0] live_pick();
        return 10'(live_idx[$urandom_range(0, live_idx.size() - 1)]);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_extreme_loads();
        load_vertex(10'd0,    {21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF},
                              {21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF});
        load_vertex(10'd1023, {21'h100000, 21'h100000, 21'h100000},
                              {21'h100000, 21'h100000, 21'h100000});
        load_vertex(10'd1,    {21'd4096, 21'd0, 21'd0}, {21'd0, 21'd0, 21'd524288});
        load_vertex(10'd2,    {21'd0, 21'd4096, 21'd0}, {21'd0, 21'd0, 21'd524288});
    endtask

    task automatic test_directed_frames();
        // plain triangle, weights sum to one
        send_word(frame_word(10'd0, 10'd1, 10'd2, 16'sd5461, 16'sd5461, 16'sd5462));
        // largest weights on extreme entries drive every sum to saturation
        send_word(frame_word(10'd0, 10'd0, 10'd0, 16'sd32767, 16'sd32767, 16'sd32767));
        send_word(frame_word(10'd1023, 10'd1023, 10'd0,
                             -16'sd32768, -16'sd32768, 16'sd32767));
        // zero weights: zero origin and zero normal sum
        send_word(frame_word(10'd1, 10'd2, 10'd0, 16'sd0, 16'sd0, 16'sd0));
        // weight ties: first corner with the lowest weight wins
        send_word(frame_word(10'd1, 10'd2, 10'd1023, 16'sd100, 16'sd100, 16'sd200));
        send_word(frame_word(10'd0, 10'd1, 10'd2, 16'sd300, 16'sd100, 16'sd100));
        // one corner at full weight, up from corner b, first of the tied zero weights
        send_word(frame_word(10'd1, 10'd2, 10'd0, 16'sd16384, 16'sd0, 16'sd0));
    endtask

    task automatic test_unused_opcode();
        t_in_word w;
        w = noise_word();
        w.opcode = OP_UNUSED;
        send_word(w);
        // table must be untouched afterwards
        send_word(frame_word(10'd2, 10'd1, 10'd0, 16'sd8192, 16'sd8192, -16'sd1));
    endtask

    task automatic test_random_traffic(int count);
        int          sel;
        logic [15:0] wa, wb, wc;
        t_in_word    w;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                w = noise_word();
                w.opcode = OP_UNUSED;
                send_word(w);
            end else if (sel < 24) begin
                load_vertex(($urandom_range(0, 1) == 1) ? live_pick()
                                                        : 10'($urandom_range(0, 1023)),
                            pick_pos(), pick_nrm());
                n++;
            end else if (sel < 30) begin
                // lone load on an already readable entry
                send_word(load_word($urandom_range(0, 1) ? OP_LOAD_NRM : OP_LOAD_POS,
                                    live_pick(),
                                    $urandom_range(0, 1) ? pick_nrm() : pick_pos()));
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        wa = 16'($urandom);
                        wb = 16'($urandom);
                        wc = 16'($urandom);
                    end
                    1: begin
                        wa = $urandom_range(0, 1) ? 16'sd4000 : -16'sd4000;
                        wb = wa;
                        wc = $urandom_range(0, 1) ? wa : 16'($urandom_range(0, 16384));
                    end
                    default: begin
                        wa = 16'($urandom_range(0, 16384));
                        wb = 16'($urandom_range(0, 16384));
                        wc = 16'sd16384 - wa - wb;
                    end
                endcase
                send_word(frame_word(live_pick(), live_pick(), live_pick(), wa, wb, wc));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_in        = '0;
        err_count   = 0;
        burst_left  = 0;
        burst_nogap = 0;
        for (int i = 0; i < 1024; i++) begin
            mesh_pos[i] = '0;
            mesh_nrm[i] = '0;
            pos_set[i]  = 1'b0;
            nrm_set[i]  = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extreme_loads();
        test_directed_frames();
        test_unused_opcode();
        hold_until_drained();
        test_random_traffic(RANDOM_ITEMS / 2);
        hold_until_drained();
        test_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2);
        hold_until_drained();

        if (err_count == 0) begin
            $display("barycentric_surface_frame_top test passed");
        end else begin
            $display("barycentric_surface_frame_top test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/bsf_pkg.sv
hdl/bsf_norm.sv
hdl/barycentric_surface_frame_top.sv
verif/tb.sv
